// ===== hw/rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, constants and helpers of the sensor frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int SFD_MAX_SENSORS = 4;

    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 2;
    localparam int KIND_W    = 3;
    localparam int READING_W = 16;
    localparam int NCNT_W    = 7;    // triplet count of an 8-bit length: at most 85

    localparam logic [BYTE_W-1:0] FRAME_HEADER  = 8'h68;
    localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd6;
    localparam logic [BYTE_W-1:0] KIND_MAX      = 8'd5;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_BAD_HEADER = 3'd1,
        STAT_BAD_LEN    = 3'd2,
        STAT_CHECKSUM   = 3'd3,
        STAT_TOO_MANY   = 3'd4
    } sfd_status_t;

    typedef enum logic {
        ST_RECV,
        ST_EMIT
    } sfd_state_t;

    // controller -> datapath
    typedef struct packed {
        logic take;    // accept the input word this cycle
        logic emit;    // load the next result into the output register
    } sfd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;     // output register empty or being drained
        logic emit_last;    // the result about to be emitted closes the frame
    } sfd_stat_t;

    // known sensor types pass through, anything else reads as unknown
    function automatic logic [KIND_W-1:0] map_kind(input logic [BYTE_W-1:0] b);
        logic [KIND_W-1:0] k;
        begin
            k = '0;
            if (b != '0 && b <= KIND_MAX)
            begin
                k = b[KIND_W-1:0];
            end
            return k;
        end
    endfunction

endpackage

// ===== hw/rtl/sfd_in_if.sv =====
// ----------------------------------------------------------------------------
// sfd_in_if
// Byte stream channel into the decoder: one frame byte per word.
// ----------------------------------------------------------------------------
interface sfd_in_if
    import sfd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

// ===== hw/rtl/sfd_out_if.sv =====
// ----------------------------------------------------------------------------
// sfd_out_if
// Result channel of the decoder: one sensor record or reject per word.
// ----------------------------------------------------------------------------
interface sfd_out_if
    import sfd_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic        [STATUS_W-1:0]  status;
    logic        [SLOT_W-1:0]    slot;
    logic        [KIND_W-1:0]    sensor_kind;
    logic signed [READING_W-1:0] reading;
    logic                        last;

    modport source (output valid, output status, output slot, output sensor_kind,
                    output reading, output last, input ready);
    modport sink   (input valid, input status, input slot, input sensor_kind,
                    input reading, input last, output ready);
endinterface

// ===== hw/rtl/sfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfd_ctrl
// Controller: receive phase takes bytes, emit phase drains the results.
// ----------------------------------------------------------------------------
module sfd_ctrl
    import sfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      frame_end,
    output logic      in_ready,
    input  sfd_stat_t stat,
    output sfd_cmd_t  cmd
);

    sfd_state_t state_reg;
    sfd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RECV;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RECV:
            begin
                if (in_valid && frame_end)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free && stat.emit_last)
                begin
                    state_next = ST_RECV;
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_RECV:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_EMIT:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/sfd_datapath.sv =====
// ----------------------------------------------------------------------------
// sfd_datapath
// Frame parser state, triplet stores, frame checks and output register.
// ----------------------------------------------------------------------------
module sfd_datapath
    import sfd_pkg::*;
#(
    parameter int MAX_SENSORS = SFD_MAX_SENSORS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  sfd_cmd_t                    cmd,
    output sfd_stat_t                   stat,
    input  logic        [BYTE_W-1:0]    data_byte,
    input  logic                        frame_end,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic        [STATUS_W-1:0]  out_status,
    output logic        [SLOT_W-1:0]    out_slot,
    output logic        [KIND_W-1:0]    out_kind,
    output logic signed [READING_W-1:0] out_reading,
    output logic                        out_last
);

    localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int CNT_W = $clog2(MAX_SENSORS + 1);
    localparam logic [CNT_W-1:0]  SIDX_LIMIT = CNT_W'(MAX_SENSORS);
    localparam logic [NCNT_W-1:0] N_LIMIT    = NCNT_W'(MAX_SENSORS);

    // frame parser state
    logic [BYTE_W-1:0] count_reg,   count_next;
    logic [BYTE_W-1:0] xor_reg,     xor_next;
    logic [BYTE_W-1:0] len_reg,     len_next;
    logic [NCNT_W-1:0] len_n_reg,   len_n_next;
    logic              len_mod0_reg, len_mod0_next;
    logic              hdr_ok_reg,  hdr_ok_next;
    logic              ovl_reg,     ovl_next;
    logic [1:0]        part_reg,    part_next;
    logic [CNT_W-1:0]  sidx_reg,    sidx_next;

    // result side
    sfd_status_t       res_status_reg, res_status_next;
    logic [NCNT_W-1:0] res_n_reg,      res_n_next;
    logic [IDX_W-1:0]  emit_idx_reg,   emit_idx_next;
    logic              out_valid_reg,  out_valid_next;

    logic        [STATUS_W-1:0]  out_status_reg;
    logic        [SLOT_W-1:0]    out_slot_reg;
    logic        [KIND_W-1:0]    out_kind_reg;
    logic signed [READING_W-1:0] out_reading_reg;
    logic                        out_last_reg;

    // triplet stores
    logic [KIND_W-1:0] kind_store [MAX_SENSORS];
    logic [BYTE_W-1:0] lo_store   [MAX_SENSORS];
    logic [BYTE_W-1:0] hi_store   [MAX_SENSORS];

    logic [BYTE_W-1:0]   count_inc;
    logic [BYTE_W-1:0]   xor_now;
    logic                ovl_now;
    logic                hdr_now;
    logic                pos0;
    logic                pos1;
    logic [2*BYTE_W-1:0] len_prod;
    logic [NCNT_W-1:0]   len_n_calc;
    logic [BYTE_W:0]     len_n_x3;
    logic                len_bad;
    sfd_status_t         end_status;
    logic                store_wr;
    logic [IDX_W-1:0]    wr_idx;

    assign count_inc = count_reg + 8'd1;
    assign xor_now   = xor_reg ^ data_byte;
    assign ovl_now   = ovl_reg | (count_inc == '0);
    assign pos0      = (count_reg == 8'd0);
    assign pos1      = (count_reg == 8'd1);
    assign hdr_now   = (!ovl_reg && pos0) ? (data_byte == FRAME_HEADER) : hdr_ok_reg;

    // L/3 as L*171 >> 9, exact for any 8-bit L
    assign len_prod   = 16'(data_byte) * 16'd171;
    assign len_n_calc = len_prod[15:9];
    assign len_n_x3   = {1'b0, len_n_calc, 1'b0} + 9'(len_n_calc);

    assign len_bad = ovl_now || (count_inc < MIN_FRAME_LEN)
                     || ({1'b0, count_inc} != ({1'b0, len_reg} + 9'd3))
                     || !len_mod0_reg;

    always_comb
    begin
        if (!hdr_now)
        begin
            end_status = STAT_BAD_HEADER;
        end
        else if (len_bad)
        begin
            end_status = STAT_BAD_LEN;
        end
        else if (xor_now != '0)
        begin
            end_status = STAT_CHECKSUM;
        end
        else if (len_n_reg > N_LIMIT)
        begin
            end_status = STAT_TOO_MANY;
        end
        else
        begin
            end_status = STAT_OK;
        end
    end

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.emit_last = (res_status_reg != STAT_OK)
                            || ((NCNT_W'(emit_idx_reg) + 7'd1) == res_n_reg);

    always_comb
    begin
        count_next      = count_reg;
        xor_next        = xor_reg;
        len_next        = len_reg;
        len_n_next      = len_n_reg;
        len_mod0_next   = len_mod0_reg;
        hdr_ok_next     = hdr_ok_reg;
        ovl_next        = ovl_reg;
        part_next       = part_reg;
        sidx_next       = sidx_reg;
        res_status_next = res_status_reg;
        res_n_next      = res_n_reg;
        emit_idx_next   = emit_idx_reg;
        out_valid_next  = out_valid_reg;

        if (cmd.take)
        begin
            count_next = count_inc;
            xor_next   = xor_now;
            ovl_next   = ovl_now;
            if (!ovl_reg)
            begin
                if (pos0)
                begin
                    hdr_ok_next = hdr_now;
                end
                else if (pos1)
                begin
                    len_next      = data_byte;
                    len_n_next    = len_n_calc;
                    len_mod0_next = (len_n_x3 == {1'b0, data_byte});
                end
                else if (part_reg == 2'd2)
                begin
                    part_next = 2'd0;
                    if (sidx_reg < SIDX_LIMIT)
                    begin
                        sidx_next = sidx_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    part_next = part_reg + 2'd1;
                end
            end
            if (frame_end)
            begin
                res_status_next = end_status;
                res_n_next      = len_n_reg;
                emit_idx_next   = '0;
                count_next      = '0;
                xor_next        = '0;
                len_next        = '0;
                len_n_next      = '0;
                len_mod0_next   = 1'b1;
                hdr_ok_next     = 1'b0;
                ovl_next        = 1'b0;
                part_next       = '0;
                sidx_next       = '0;
            end
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            emit_idx_next  = emit_idx_reg + IDX_W'(1);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            xor_reg        <= '0;
            len_reg        <= '0;
            len_n_reg      <= '0;
            len_mod0_reg   <= 1'b1;
            hdr_ok_reg     <= 1'b0;
            ovl_reg        <= 1'b0;
            part_reg       <= '0;
            sidx_reg       <= '0;
            res_status_reg <= STAT_OK;
            res_n_reg      <= '0;
            emit_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            xor_reg        <= xor_next;
            len_reg        <= len_next;
            len_n_reg      <= len_n_next;
            len_mod0_reg   <= len_mod0_next;
            hdr_ok_reg     <= hdr_ok_next;
            ovl_reg        <= ovl_next;
            part_reg       <= part_next;
            sidx_reg       <= sidx_next;
            res_status_reg <= res_status_next;
            res_n_reg      <= res_n_next;
            emit_idx_reg   <= emit_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // triplets past the store depth are dropped
    assign store_wr = cmd.take && !ovl_reg && !pos0 && !pos1 && (sidx_reg < SIDX_LIMIT);
    assign wr_idx   = sidx_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            case (part_reg)
                2'd0:    kind_store[wr_idx] <= map_kind(data_byte);
                2'd1:    lo_store[wr_idx]   <= data_byte;
                default: hi_store[wr_idx]   <= data_byte;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_last_reg   <= stat.emit_last;
            if (res_status_reg == STAT_OK)
            begin
                out_slot_reg    <= SLOT_W'(emit_idx_reg);
                out_kind_reg    <= kind_store[emit_idx_reg];
                out_reading_reg <= $signed({hi_store[emit_idx_reg], lo_store[emit_idx_reg]});
            end
            else
            begin
                out_slot_reg    <= '0;
                out_kind_reg    <= '0;
                out_reading_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_slot    = out_slot_reg;
    assign out_kind    = out_kind_reg;
    assign out_reading = out_reading_reg;
    assign out_last    = out_last_reg;

endmodule

// ===== hw/rtl/sensor_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_decoder_top
// Sensor frame decoder: parses a byte framed packet and emits sensor records.
// ----------------------------------------------------------------------------
// Frames arrive one byte per word, the final byte flagged with frame_end. While
// a frame is being received a byte is taken every cycle, even while the previous
// result still sits in the output register. The final byte switches the block
// into its emit phase, where the output register sends one word per cycle
// (given ready): one record per triplet for a good frame, or a single reject
// word with the status code and last set. Input is held off during that phase.
// Frames with more than MAX_SENSORS triplets that pass the other checks are
// rejected with status 4.
module sensor_frame_decoder_top
    import sfd_pkg::*;
#(
    parameter int MAX_SENSORS = SFD_MAX_SENSORS
)
(
    input  logic      clk,
    input  logic      rst_n,
    sfd_in_if.sink    in_ch,
    sfd_out_if.source out_ch
);

    sfd_cmd_t  cmd;
    sfd_stat_t stat;

    sfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .frame_end (in_ch.frame_end),
        .in_ready  (in_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sfd_datapath #(
        .MAX_SENSORS (MAX_SENSORS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .data_byte   (in_ch.data_byte),
        .frame_end   (in_ch.frame_end),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .out_status  (out_ch.status),
        .out_slot    (out_ch.slot),
        .out_kind    (out_ch.sensor_kind),
        .out_reading (out_ch.reading),
        .out_last    (out_ch.last)
    );

`ifndef SYNTH
    a_end_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.frame_end) |=> !in_ch.ready)
        else $error("input still ready after final byte");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status != STAT_OK) |->
        (out_ch.last && out_ch.slot == '0 && out_ch.sensor_kind == '0
         && out_ch.reading == '0))
        else $error("reject word with stray fields");

    a_records_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && !out_ch.last) |=>
        (out_ch.valid && out_ch.status == STAT_OK))
        else $error("record sequence broken");

    a_no_input_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.last) |-> !in_ch.ready)
        else $error("input taken while records pending");
`endif

endmodule
